FILE: rtl/fqd_pkg.sv
// Shared types and constants for the FIFO queue with delete-by-value.
`default_nettype none
package fqd_pkg;

  localparam int CMD_W   = 2;
  localparam int ITEM_W  = 32;
  localparam int COUNT_W = 5;

  // Input transaction commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_DEL = 2'd2,
    CMD_LEN = 2'd3
  } fqd_cmd_t;

  // Result status codes
  localparam logic STS_OK  = 1'b0;
  localparam logic STS_ERR = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ENQ,
    OP_DEQ,
    OP_DEL_LOAD,
    OP_ROTATE
  } fqd_op_t;

  // Controller to datapath
  typedef struct packed {
    fqd_op_t op;
  } fqd_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic item_zero;
    logic steps_zero;
    logic found;
  } fqd_sts_t;

endpackage : fqd_pkg
`default_nettype wire

FILE: rtl/fifo_queue_with_delete.sv
// Top level: ordered FIFO of nonzero handles with dequeue, delete-by-value and length.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  input   | start, busy          | in_cmd[1:0], in_item[31:0]
//  result  | out_strobe           | out_status, out_item_out[31:0], out_count[4:0]
//
// Enqueue, dequeue, length and null delete: result strobes the cycle after start;
// one transaction per cycle while busy is low.
// Delete of a nonzero handle: the entry shift line rotates once per stored entry, comparing
// only the head slot, so busy stays high for the whole scan and the result strobes
// in the cycle in which busy falls.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
// The receiver cannot stall: each result is valid for exactly the one strobe cycle.
`default_nettype none
module fifo_queue_with_delete #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [fqd_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [fqd_pkg::ITEM_W-1:0]  in_item,
  output logic                             out_strobe,
  output logic                             out_status,
  output logic [fqd_pkg::ITEM_W-1:0]       out_item_out,
  output logic [fqd_pkg::COUNT_W-1:0]      out_count
);
  import fqd_pkg::*;

  fqd_ctl_t ctl;
  fqd_sts_t sts;

  fqd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_cmd     (in_cmd),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_status (out_status)
  );

  fqd_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_item),
    .ctl          (ctl),
    .sts          (sts),
    .out_item_out (out_item_out),
    .out_count    (out_count)
  );

  // Valid enqueue into a non-full queue succeeds next cycle
  a_enq_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_ENQ && in_item != '0 && !sts.full)
      |=> (out_strobe && out_status == STS_OK))
    else $error("valid enqueue did not complete");

  // Non-delete transactions strobe their result in the cycle after start
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != CMD_DEL) |=> out_strobe)
    else $error("non-delete transaction missed its result cycle");

  // Errors never return a handle
  a_err_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STS_ERR) |-> (out_item_out == '0))
    else $error("error result carries a handle");

  // No result while a delete scan is running
  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobed during delete scan");

endmodule : fifo_queue_with_delete
`default_nettype wire

FILE: rtl/fqd_dpath.sv
// Datapath: compacted entry shift line, occupancy, delete scan counter and result item.
`default_nettype none
module fqd_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [fqd_pkg::ITEM_W-1:0] in_item,
  input  fqd_pkg::fqd_ctl_t              ctl,
  output fqd_pkg::fqd_sts_t              sts,
  output logic [fqd_pkg::ITEM_W-1:0]     out_item_out,
  output logic [fqd_pkg::COUNT_W-1:0]    out_count
);
  import fqd_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [ITEM_W-1:0] slot_r   [QUEUE_DEPTH];
  logic [ITEM_W-1:0] slot_nxt [QUEUE_DEPTH];
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [OCC_W-1:0]  steps_r, steps_nxt;
  logic              found_r, found_nxt;
  logic [ITEM_W-1:0] key_r, key_nxt;
  logic [ITEM_W-1:0] item_out_r, item_out_nxt;
  logic [OCC_W-1:0]  tail_idx;
  logic              head_match;

  // First match only: once found, later equal entries are kept
  assign head_match = (slot_r[0] == key_r) && !found_r;
  assign tail_idx   = occ_r - OCC_W'(1);

  // Entry shift line: slot 0 is the oldest entry
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
      case (ctl.op)
        OP_ENQ: begin
          if (occ_r == OCC_W'(i)) slot_nxt[i] = in_item;
        end
        OP_DEQ: begin
          if (i < QUEUE_DEPTH - 1) slot_nxt[i] = slot_r[(i + 1) % QUEUE_DEPTH];
        end
        OP_ROTATE: begin
          // head moves to the tail unless it is the entry being deleted
          if (!head_match && tail_idx == OCC_W'(i)) begin
            slot_nxt[i] = slot_r[0];
          end else if (i < QUEUE_DEPTH - 1) begin
            slot_nxt[i] = slot_r[(i + 1) % QUEUE_DEPTH];
          end
        end
        default: ;
      endcase
    end
  end

  // Occupancy, scan counter and match state
  always_comb begin
    occ_nxt      = occ_r;
    steps_nxt    = steps_r;
    found_nxt    = found_r;
    key_nxt      = key_r;
    item_out_nxt = '0;
    case (ctl.op)
      OP_ENQ: occ_nxt = occ_r + OCC_W'(1);
      OP_DEQ: begin
        occ_nxt      = occ_r - OCC_W'(1);
        item_out_nxt = slot_r[0];
      end
      OP_DEL_LOAD: begin
        steps_nxt = occ_r;
        found_nxt = 1'b0;
        key_nxt   = in_item;
      end
      OP_ROTATE: begin
        steps_nxt = steps_r - OCC_W'(1);
        if (head_match) begin
          found_nxt = 1'b1;
          occ_nxt   = occ_r - OCC_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      steps_r <= '0;
      found_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      steps_r <= steps_nxt;
      found_r <= found_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_r[i] <= slot_nxt[i];
    key_r      <= key_nxt;
    item_out_r <= item_out_nxt;
  end

  assign sts.empty      = (occ_r == '0);
  assign sts.full       = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign sts.item_zero  = (in_item == '0);
  assign sts.steps_zero = (steps_r == '0);
  assign sts.found      = found_r;

  assign out_item_out = item_out_r;
  assign out_count    = COUNT_W'(occ_r);

endmodule : fqd_dpath
`default_nettype wire

FILE: rtl/fqd_ctrl.sv
// Controller: command decode, delete scan sequencing and result strobe.
`default_nettype none
module fqd_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [fqd_pkg::CMD_W-1:0] in_cmd,
  input  fqd_pkg::fqd_sts_t             sts,
  output fqd_pkg::fqd_ctl_t             ctl,
  output logic                          busy,
  output logic                          out_strobe,
  output logic                          out_status
);
  import fqd_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t   state_r, state_nxt;
  logic     strobe_r, strobe_nxt;
  logic     status_r, status_nxt;
  fqd_cmd_t cmd;

  assign cmd = fqd_cmd_t'(in_cmd);

  // Next state, datapath op and result status
  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    ctl.op     = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          status_nxt = STS_OK;
          case (cmd)
            CMD_ENQ: begin
              if (sts.item_zero || sts.full) status_nxt = STS_ERR;
              else ctl.op = OP_ENQ;
            end
            CMD_DEQ: begin
              if (sts.empty) status_nxt = STS_ERR;
              else ctl.op = OP_DEQ;
            end
            CMD_DEL: begin
              if (sts.item_zero) begin
                status_nxt = STS_ERR;
              end else begin
                strobe_nxt = 1'b0;
                ctl.op     = OP_DEL_LOAD;
                state_nxt  = S_SCAN;
              end
            end
            default: ;  // length query: count only
          endcase
        end
      end
      S_SCAN: begin
        if (sts.steps_zero) begin
          strobe_nxt = 1'b1;
          status_nxt = sts.found ? STS_OK : STS_ERR;
          state_nxt  = S_IDLE;
        end else begin
          ctl.op = OP_ROTATE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      status_r <= STS_OK;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_status = status_r;

endmodule : fqd_ctrl
`default_nettype wire
